FILE: src/gfec_pkg.sv
// ============================================================================
// gfec_pkg: shared types and constants of the gap-following effort controller
// Holds the control word layout, operation codes, configuration register
// indexes and the configuration bundle passed from the top level to the
// datapath.
// ============================================================================
package gfec_pkg;

    localparam int unsigned PC_W = 4;
    typedef logic [PC_W-1:0] pc_t;

    // Mode codes carried by the func field.
    localparam logic [1:0] FUNC_FOLLOW  = 2'd0;
    localparam logic [1:0] FUNC_PROTECT = 2'd1;
    localparam logic [1:0] FUNC_DRIFT   = 2'd2;
    localparam logic [1:0] FUNC_NONE    = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_STANDOFF = 3'd0;
    localparam logic [2:0] CFG_HEADWAY  = 3'd1;
    localparam logic [2:0] CFG_STEP     = 3'd2;
    localparam logic [2:0] CFG_FOLLOW   = 3'd3;
    localparam logic [2:0] CFG_PROTECT  = 3'd4;
    localparam logic [2:0] CFG_DRIFT    = 3'd5;

    // Multiplier operand A sources.
    localparam logic [2:0] MA_HEADWAY = 3'd0;
    localparam logic [2:0] MA_KP      = 3'd1;
    localparam logic [2:0] MA_KI      = 3'd2;
    localparam logic [2:0] MA_KD      = 3'd3;
    localparam logic [2:0] MA_PROD    = 3'd4;

    // Multiplier operand B sources.
    localparam logic [1:0] MB_SPEED = 2'd0;
    localparam logic [1:0] MB_ERR   = 2'd1;
    localparam logic [1:0] MB_STEP  = 2'd2;
    localparam logic [1:0] MB_REL   = 2'd3;

    // Accumulator and result operations.
    localparam logic [3:0] OP_NOP       = 4'd0;
    localparam logic [3:0] OP_SETPT     = 4'd1;
    localparam logic [3:0] OP_ERR_FP    = 4'd2;
    localparam logic [3:0] OP_ERR_DRIFT = 4'd3;
    localparam logic [3:0] OP_INC       = 4'd4;
    localparam logic [3:0] OP_CLAMP     = 4'd5;
    localparam logic [3:0] OP_SUM_INIT  = 4'd6;
    localparam logic [3:0] OP_SUM_ADD   = 4'd7;
    localparam logic [3:0] OP_OUT       = 4'd8;

    // Sequencer jump kinds.
    localparam logic [1:0] JMP_NONE   = 2'd0;
    localparam logic [1:0] JMP_DRIFT  = 2'd1;
    localparam logic [1:0] JMP_ALWAYS = 2'd2;

    // Program entry points.
    localparam pc_t STEP_START = 4'd0;
    localparam pc_t STEP_OUT   = 4'd9;
    localparam pc_t STEP_DRIFT = 4'd10;

    typedef struct packed {
        logic       mul_en;
        logic [2:0] mul_a;
        logic [1:0] mul_b;
        logic [3:0] alu_op;
        logic [1:0] jmp;
        pc_t        target;
        logic       last;
    } ucode_t;

    typedef struct packed {
        logic [15:0] standoff_distance;
        logic [15:0] time_headway;
        logic [15:0] step_time;
        logic [47:0] follow_gains;
        logic [47:0] protect_gains;
        logic [31:0] drift_gains;
    } cfg_t;

endpackage

FILE: src/gfec_ucode_rom.sv
// ============================================================================
// gfec_ucode_rom: control store of the effort sequencer
// Returns the control word of one program step.
// ============================================================================
module gfec_ucode_rom (
    input  gfec_pkg::pc_t    pc,
    output gfec_pkg::ucode_t cw
);
    import gfec_pkg::*;

    // Fields: mul_en, mul_a, mul_b, alu_op, jmp, target, last.
    always_comb
    begin
        unique case (pc)
            4'd0:  cw = '{1'b1, MA_HEADWAY, MB_SPEED, OP_NOP,       JMP_DRIFT,  STEP_DRIFT, 1'b0};
            4'd1:  cw = '{1'b0, MA_HEADWAY, MB_SPEED, OP_SETPT,     JMP_NONE,   STEP_START, 1'b0};
            4'd2:  cw = '{1'b0, MA_HEADWAY, MB_SPEED, OP_ERR_FP,    JMP_NONE,   STEP_START, 1'b0};
            4'd3:  cw = '{1'b1, MA_KI,      MB_ERR,   OP_NOP,       JMP_NONE,   STEP_START, 1'b0};
            4'd4:  cw = '{1'b1, MA_PROD,    MB_STEP,  OP_NOP,       JMP_NONE,   STEP_START, 1'b0};
            4'd5:  cw = '{1'b1, MA_KP,      MB_ERR,   OP_INC,       JMP_NONE,   STEP_START, 1'b0};
            4'd6:  cw = '{1'b0, MA_KP,      MB_ERR,   OP_CLAMP,     JMP_NONE,   STEP_START, 1'b0};
            4'd7:  cw = '{1'b1, MA_KD,      MB_REL,   OP_SUM_INIT,  JMP_NONE,   STEP_START, 1'b0};
            4'd8:  cw = '{1'b0, MA_KD,      MB_REL,   OP_SUM_ADD,   JMP_NONE,   STEP_START, 1'b0};
            4'd9:  cw = '{1'b0, MA_KD,      MB_REL,   OP_OUT,       JMP_NONE,   STEP_START, 1'b1};
            4'd10: cw = '{1'b0, MA_KI,      MB_ERR,   OP_ERR_DRIFT, JMP_NONE,   STEP_START, 1'b0};
            4'd11: cw = '{1'b1, MA_KI,      MB_ERR,   OP_NOP,       JMP_NONE,   STEP_START, 1'b0};
            4'd12: cw = '{1'b1, MA_PROD,    MB_STEP,  OP_NOP,       JMP_NONE,   STEP_START, 1'b0};
            4'd13: cw = '{1'b1, MA_KP,      MB_ERR,   OP_INC,       JMP_NONE,   STEP_START, 1'b0};
            4'd14: cw = '{1'b0, MA_KP,      MB_ERR,   OP_CLAMP,     JMP_NONE,   STEP_START, 1'b0};
            4'd15: cw = '{1'b0, MA_KP,      MB_ERR,   OP_SUM_INIT,  JMP_ALWAYS, STEP_OUT,   1'b0};
            default: cw = '0;
        endcase
    end

endmodule

FILE: src/gfec_datapath.sv
// ============================================================================
// gfec_datapath: shared multiplier, accumulator and integrator store
// Executes one control word per enabled cycle on the latched tick fields.
// ============================================================================
module gfec_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic                step_en,
    input  gfec_pkg::ucode_t    cw,
    input  gfec_pkg::cfg_t      cfg,
    input  logic [1:0]          func,
    input  logic [15:0]         gap,
    input  logic [15:0]         ego_speed,
    input  logic signed [15:0]  closing_speed,
    input  logic signed [15:0]  speed_error,
    input  logic [15:0]         effort_limit,
    output logic                drift,
    output logic [15:0]         effort
);
    import gfec_pkg::*;

    localparam logic signed [35:0] SAT_HI = 36'sd32767;
    localparam logic signed [35:0] SAT_LO = -36'sd32768;

    logic [1:0]          mode_reg;
    logic [15:0]         gap_reg;
    logic [15:0]         speed_reg;
    logic signed [15:0]  rel_reg;
    logic signed [15:0]  verr_reg;
    logic [15:0]         maxe_reg;
    logic signed [15:0]  err_reg,   err_next;
    logic signed [35:0]  acc_reg,   acc_next;
    logic signed [50:0]  prod_reg;
    logic [31:0]         integ_reg, integ_next;
    logic [15:0]         effort_reg, effort_next;
    logic [31:0]         store_reg [3];

    logic [15:0]         kp, ki, kd;
    logic signed [33:0]  op_a;
    logic signed [16:0]  op_b;
    logic signed [50:0]  mul_out;
    logic [31:0]         ceil_q;
    logic signed [35:0]  ceil_x;
    logic signed [35:0]  gap_x;
    logic signed [35:0]  diff;
    logic signed [35:0]  inc_x;
    logic [31:0]         store_rd;

    assign drift  = (mode_reg == FUNC_DRIFT);
    assign effort = effort_reg;

    // Gain selection by mode; drift has no derivative gain.
    always_comb
    begin
        unique case (mode_reg)
            FUNC_FOLLOW:
            begin
                kp = cfg.follow_gains[15:0];
                ki = cfg.follow_gains[31:16];
                kd = cfg.follow_gains[47:32];
            end
            FUNC_PROTECT:
            begin
                kp = cfg.protect_gains[15:0];
                ki = cfg.protect_gains[31:16];
                kd = cfg.protect_gains[47:32];
            end
            default:
            begin
                kp = cfg.drift_gains[15:0];
                ki = cfg.drift_gains[31:16];
                kd = 16'd0;
            end
        endcase
    end

    always_comb
    begin
        case (cw.mul_a)
            MA_HEADWAY: op_a = $signed({18'd0, cfg.time_headway});
            MA_KP:      op_a = $signed({18'd0, kp});
            MA_KI:      op_a = $signed({18'd0, ki});
            MA_KD:      op_a = $signed({18'd0, kd});
            MA_PROD:    op_a = $signed(prod_reg[33:0]);
            default:    op_a = '0;
        endcase
        case (cw.mul_b)
            MB_SPEED: op_b = $signed({1'b0, speed_reg});
            MB_ERR:   op_b = $signed({err_reg[15], err_reg});
            MB_STEP:  op_b = $signed({1'b0, cfg.step_time});
            default:  op_b = $signed({rel_reg[15], rel_reg});
        endcase
    end

    assign mul_out = op_a * op_b;

    always_comb
    begin
        case (mode_reg)
            FUNC_FOLLOW:  store_rd = store_reg[0];
            FUNC_PROTECT: store_rd = store_reg[1];
            FUNC_DRIFT:   store_rd = store_reg[2];
            default:      store_rd = 32'd0;
        endcase
    end

    assign ceil_q = {maxe_reg, 16'd0};
    assign ceil_x = $signed({4'd0, ceil_q});
    assign gap_x  = $signed({20'd0, gap_reg});
    assign diff   = (mode_reg == FUNC_PROTECT) ? (acc_reg - gap_x) : (gap_x - acc_reg);
    // Floor of the Q16.16 increment is an arithmetic shift of the product.
    assign inc_x  = $signed({prod_reg[50], prod_reg[50:16]});

    always_comb
    begin
        acc_next    = acc_reg;
        err_next    = err_reg;
        integ_next  = integ_reg;
        effort_next = effort_reg;
        unique case (cw.alu_op)
            OP_NOP:
            begin
                acc_next = acc_reg;
            end
            OP_SETPT:
            begin
                acc_next = $signed({20'd0, cfg.standoff_distance})
                         + $signed({16'd0, prod_reg[31:12]});
            end
            OP_ERR_FP:
            begin
                if (diff > SAT_HI)
                    err_next = 16'sh7FFF;
                else if (diff < SAT_LO)
                    err_next = 16'sh8000;
                else
                    err_next = diff[15:0];
            end
            OP_ERR_DRIFT:
            begin
                err_next = verr_reg;
            end
            OP_INC:
            begin
                acc_next = $signed({4'd0, store_rd}) + inc_x;
            end
            OP_CLAMP:
            begin
                if (acc_reg[35])
                    integ_next = 32'd0;
                else if (acc_reg > ceil_x)
                    integ_next = ceil_q;
                else
                    integ_next = acc_reg[31:0];
            end
            OP_SUM_INIT:
            begin
                acc_next = $signed({4'd0, integ_reg}) + $signed(prod_reg[35:0]);
            end
            OP_SUM_ADD:
            begin
                acc_next = acc_reg + $signed(prod_reg[35:0]);
            end
            OP_OUT:
            begin
                if (acc_reg[35])
                    effort_next = 16'd0;
                else if (acc_reg > ceil_x)
                    effort_next = maxe_reg;
                else
                    effort_next = acc_reg[31:16];
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mode_reg  <= func;
            gap_reg   <= gap;
            speed_reg <= ego_speed;
            rel_reg   <= closing_speed;
            verr_reg  <= speed_error;
            maxe_reg  <= effort_limit;
            acc_reg   <= '0;
        end
        else if (step_en)
        begin
            acc_reg    <= acc_next;
            err_reg    <= err_next;
            integ_reg  <= integ_next;
            effort_reg <= effort_next;
            if (cw.mul_en)
                prod_reg <= mul_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_reg[0] <= 32'd0;
            store_reg[1] <= 32'd0;
            store_reg[2] <= 32'd0;
        end
        else if (step_en && cw.alu_op == OP_CLAMP)
        begin
            case (mode_reg)
                FUNC_FOLLOW:  store_reg[0] <= integ_next;
                FUNC_PROTECT: store_reg[1] <= integ_next;
                FUNC_DRIFT:   store_reg[2] <= integ_next;
                default:      store_reg[0] <= store_reg[0];
            endcase
        end
    end

endmodule

FILE: src/gap_following_effort_controller.sv
// ============================================================================
// gap_following_effort_controller: spacing and speed PI(D) effort controller
// Top level: configuration registers, input and output transactions and the
// microprogram sequencer that steps the datapath.
// ============================================================================
// Each accepted input transaction is one control tick and yields exactly one
// effort result. The tick is processed by a short microprogram that drives
// a single shared multiplier: follow and protect ticks run every step from
// the first to the output step, drift ticks branch after the first step to
// a drift path that rejoins at the output step, and a tick with the unused
// mode code skips straight to the output step, returning zero without
// touching any integrator. The multiplier is shared by the headway product,
// the two-stage integral product and the proportional and derivative
// products, and that sharing sets the step count. One tick is processed at
// a time; a new tick is accepted while the previous result still waits in
// the output register, and the sequencer holds on its output step until
// that result has been taken. Configuration writes take effect at once and
// should only be issued while no tick is in flight. Each mode keeps its own
// Q16.16 integrator, cleared by reset and clamped to the tick's effort ceiling.
module gap_following_effort_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wen,
    input  logic [2:0]          cfg_index,
    input  logic [47:0]         cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          func,
    input  logic [15:0]         gap,
    input  logic [15:0]         ego_speed,
    input  logic signed [15:0]  closing_speed,
    input  logic signed [15:0]  speed_error,
    input  logic [15:0]         effort_limit,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [15:0]         effort
);
    import gfec_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    cfg_t     cfg_reg;
    logic     state_reg, state_next;
    pc_t      pc_reg, pc_next;
    logic     out_valid_reg, out_valid_next;
    ucode_t   cw;
    logic     accept;
    logic     stall;
    logic     step_en;
    logic     jump_taken;
    logic     drift;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                CFG_STANDOFF: cfg_reg.standoff_distance <= cfg_wdata[15:0];
                CFG_HEADWAY:  cfg_reg.time_headway      <= cfg_wdata[15:0];
                CFG_STEP:     cfg_reg.step_time         <= cfg_wdata[15:0];
                CFG_FOLLOW:   cfg_reg.follow_gains      <= cfg_wdata;
                CFG_PROTECT:  cfg_reg.protect_gains     <= cfg_wdata;
                CFG_DRIFT:    cfg_reg.drift_gains       <= cfg_wdata[31:0];
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    gfec_ucode_rom u_rom (
        .pc (pc_reg),
        .cw (cw)
    );

    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    // The output step waits while the previous result is still unclaimed.
    assign stall      = cw.last && out_valid_reg && !out_ready;
    assign step_en    = (state_reg == ST_RUN) && !stall;
    assign jump_taken = (cw.jmp == JMP_ALWAYS) || ((cw.jmp == JMP_DRIFT) && drift);

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                    pc_next    = (func == FUNC_NONE) ? STEP_OUT : STEP_START;
                end
            end
            ST_RUN:
            begin
                if (step_en)
                begin
                    if (cw.last)
                    begin
                        state_next     = ST_IDLE;
                        out_valid_next = 1'b1;
                    end
                    else if (jump_taken)
                        pc_next = cw.target;
                    else
                        pc_next = pc_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= STEP_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    gfec_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (accept),
        .step_en       (step_en),
        .cw            (cw),
        .cfg           (cfg_reg),
        .func          (func),
        .gap           (gap),
        .ego_speed     (ego_speed),
        .closing_speed (closing_speed),
        .speed_error   (speed_error),
        .effort_limit  (effort_limit),
        .drift         (drift),
        .effort        (effort)
    );

endmodule

FILE: src/gfec_checker.sv
// ============================================================================
// gfec_checker: port-level checks of the effort controller
// Tracks transactions in flight and checks output stability, the
// one-tick-at-a-time acceptance, no phantom result and the in-flight bound.
// ============================================================================
module gfec_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] effort
);
    logic [1:0] cnt_reg, cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_valid && in_ready && !(out_valid && out_ready))
            cnt_next = cnt_reg + 2'd1;
        else if (!(in_valid && in_ready) && out_valid && out_ready)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(effort))
        else $error("result changed or dropped while stalled");

    a_one_tick: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction accepted while a tick is in work");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cnt_reg != 2'd0)
        else $error("result offered with no transaction in flight");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |-> cnt_reg != 2'd3)
        else $error("more than two transactions in flight");

endmodule

bind gap_following_effort_controller gfec_checker u_gfec_checker (.*);
